>>> rtl/affmi_pkg.sv
// Package for the affine 3x4 matrix inverse block: payload types, command and
// status structs between controller and datapath, widths, adjugate term table.
// No dependencies.
package affmi_pkg;

    localparam int FRAC_BITS = 16;          // fraction bits of Q format
    localparam int ELEMS     = 12;          // elements of a 3x4 matrix
    localparam int COFS      = 9;           // cofactors of the 3x3 part
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 33;          // multiplier operand, signed
    localparam int PROD_W    = 2 * OP_W;
    localparam int COF_W     = 64;
    localparam int ACC_W     = 100;         // holds exact determinant
    localparam int DIV_W     = 132;         // holds |P| << 2F and |D| << 33
    localparam int QUO_W     = 33;          // quotient bits below saturation
    localparam int DIV_STEPS = QUO_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMS - 1);

    typedef struct packed {
        logic [IDX_W-1:0]        element_index;
        logic signed [VAL_W-1:0] element_value;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0]        element_index_res;
        logic signed [VAL_W-1:0] element_value_res;
        logic                    singular;
        logic                    last;
    } t_out_req;

    typedef enum logic [1:0] {LD_NONE, LD_A, LD_B} t_ld;
    typedef enum logic [1:0] {SRC_IN, SRC_INV, SRC_PLO, SRC_PHI} t_src;
    typedef enum logic [2:0] {ACC_NOP, ACC_CLR, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADDHI} t_acc;

    typedef struct packed {
        logic             wr_in;
        t_ld              ld;
        t_src             src;
        logic [IDX_W-1:0] addr;
        logic             mul;
        t_acc             acc;
        logic             p_wr;
        logic             det_wr;
        logic             div_init;
        logic             div_step;
        logic             div_fin;
        logic             trn_wr;
        logic [IDX_W-1:0] waddr;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic singular;
        logic out_full;
    } t_status;

    // cofactor dst = m[a]*m[b] - m[c]*m[d]
    typedef struct packed {
        logic [IDX_W-1:0] dst;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] d;
    } t_adj;

    function automatic t_adj f_adj(input logic [IDX_W-1:0] k);
        t_adj r;
        unique case (k)
            4'd0:    r = '{4'd0,  4'd5,  4'd10, 4'd6,  4'd9};
            4'd1:    r = '{4'd1,  4'd9,  4'd2,  4'd10, 4'd1};
            4'd2:    r = '{4'd2,  4'd1,  4'd6,  4'd2,  4'd5};
            4'd3:    r = '{4'd4,  4'd6,  4'd8,  4'd4,  4'd10};
            4'd4:    r = '{4'd5,  4'd10, 4'd0,  4'd8,  4'd2};
            4'd5:    r = '{4'd6,  4'd2,  4'd4,  4'd0,  4'd6};
            4'd6:    r = '{4'd8,  4'd4,  4'd9,  4'd5,  4'd8};
            4'd7:    r = '{4'd9,  4'd8,  4'd1,  4'd9,  4'd0};
            4'd8:    r = '{4'd10, 4'd0,  4'd5,  4'd1,  4'd4};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/affmi_ctrl.sv
// Sequencer for the affine inverse: walks cofactors, determinant, divisions,
// translation and result emission. Depends on affmi_pkg.
module affmi_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [affmi_pkg::IDX_W-1:0]  i_in_idx,
    output logic                         o_in_stall,
    input  affmi_pkg::t_status           i_status,
    output affmi_pkg::t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_COF, S_DET, S_DET_WR, S_CHK, S_DIV_INIT, S_DIV_IT,
        S_DIV_FIN, S_TRN, S_TRN_WR, S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic               r_stall, n_stall;
    logic [3:0]         r_k, n_k;
    logic [3:0]         r_step, n_step;
    logic [5:0]         r_it, n_it;
    affmi_pkg::t_adj    adj;
    affmi_pkg::t_cmd    cmd;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_step  = r_step + 4'd1;
        n_it    = r_it;
        cmd     = '0;
        adj     = affmi_pkg::f_adj(r_k);
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid && !r_stall && i_in_idx <= affmi_pkg::LAST_IDX) begin
                    cmd.wr_in = 1'b1;
                    if (i_in_idx == affmi_pkg::LAST_IDX) begin
                        n_state = S_COF;
                        n_k     = '0;
                    end
                end
            end
            S_COF: begin
                unique case (r_step)
                    4'd0: begin cmd.ld = affmi_pkg::LD_A; cmd.src = affmi_pkg::SRC_IN; cmd.addr = adj.a; end
                    4'd1: begin cmd.ld = affmi_pkg::LD_B; cmd.src = affmi_pkg::SRC_IN; cmd.addr = adj.b; end
                    4'd2: cmd.mul = 1'b1;
                    4'd3: cmd.acc = affmi_pkg::ACC_LOAD;
                    4'd4: begin cmd.ld = affmi_pkg::LD_A; cmd.src = affmi_pkg::SRC_IN; cmd.addr = adj.c; end
                    4'd5: begin cmd.ld = affmi_pkg::LD_B; cmd.src = affmi_pkg::SRC_IN; cmd.addr = adj.d; end
                    4'd6: cmd.mul = 1'b1;
                    4'd7: cmd.acc = affmi_pkg::ACC_SUB;
                    default: begin
                        cmd.p_wr  = 1'b1;
                        cmd.waddr = r_k;
                        n_step    = '0;
                        if (r_k == 4'(affmi_pkg::COFS - 1)) begin
                            n_state = S_DET;
                            n_k     = '0;
                        end else begin
                            n_k = r_k + 4'd1;
                        end
                    end
                endcase
            end
            S_DET: begin
                unique case (r_step)
                    4'd0: begin
                        cmd.ld   = affmi_pkg::LD_A;
                        cmd.src  = affmi_pkg::SRC_IN;
                        cmd.addr = {r_k[1:0], 2'b00};
                        if (r_k == 4'd0) cmd.acc = affmi_pkg::ACC_CLR;
                    end
                    4'd1: begin cmd.ld = affmi_pkg::LD_B; cmd.src = affmi_pkg::SRC_PLO; cmd.addr = r_k; end
                    4'd2: cmd.mul = 1'b1;
                    4'd3: cmd.acc = affmi_pkg::ACC_ADD;
                    4'd4: begin cmd.ld = affmi_pkg::LD_B; cmd.src = affmi_pkg::SRC_PHI; cmd.addr = r_k; end
                    4'd5: cmd.mul = 1'b1;
                    default: begin
                        cmd.acc = affmi_pkg::ACC_ADDHI;
                        n_step  = '0;
                        if (r_k == 4'd2) n_state = S_DET_WR;
                        else n_k = r_k + 4'd1;
                    end
                endcase
            end
            S_DET_WR: begin
                cmd.det_wr = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                n_k     = '0;
                n_state = i_status.singular ? S_EMIT : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cmd.addr     = r_k;
                n_it         = '0;
                n_state      = S_DIV_IT;
            end
            S_DIV_IT: begin
                cmd.div_step = 1'b1;
                if (r_it == 6'(affmi_pkg::DIV_STEPS - 1)) n_state = S_DIV_FIN;
                else n_it = r_it + 6'd1;
            end
            S_DIV_FIN: begin
                cmd.div_fin = 1'b1;
                cmd.waddr   = adj.dst;
                if (r_k == 4'(affmi_pkg::COFS - 1)) begin
                    n_state = S_TRN;
                    n_k     = '0;
                    n_it    = '0;
                    n_step  = '0;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_TRN: begin
                // r_k is the row, r_it the column
                unique case (r_step)
                    4'd0: begin
                        cmd.ld   = affmi_pkg::LD_A;
                        cmd.src  = affmi_pkg::SRC_INV;
                        cmd.addr = {r_k[1:0], r_it[1:0]};
                    end
                    4'd1: begin
                        cmd.ld   = affmi_pkg::LD_B;
                        cmd.src  = affmi_pkg::SRC_IN;
                        cmd.addr = {r_it[1:0], 2'b11};
                    end
                    4'd2: cmd.mul = 1'b1;
                    default: begin
                        cmd.acc = (r_it == 6'd0) ? affmi_pkg::ACC_LOAD : affmi_pkg::ACC_ADD;
                        n_step  = '0;
                        if (r_it == 6'd2) n_state = S_TRN_WR;
                        else n_it = r_it + 6'd1;
                    end
                endcase
            end
            S_TRN_WR: begin
                cmd.trn_wr = 1'b1;
                cmd.waddr  = {r_k[1:0], 2'b11};
                n_it       = '0;
                n_step     = '0;
                if (r_k == 4'd2) begin
                    n_state = S_EMIT;
                    n_k     = '0;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = S_TRN;
                end
            end
            S_EMIT: begin
                if (!i_status.out_full) begin
                    cmd.out_load = 1'b1;
                    cmd.addr     = r_k;
                    if (r_k == affmi_pkg::LAST_IDX) n_state = S_IDLE;
                    else n_k = r_k + 4'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b1;
            r_k     <= '0;
            r_step  <= '0;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
            r_k     <= n_k;
            r_step  <= n_step;
            r_it    <= n_it;
        end
    end

    assign o_in_stall = r_stall;
    assign o_cmd      = cmd;

endmodule

>>> rtl/affmi_dp.sv
// Datapath for the affine inverse: element stores, shared 33x33 multiplier,
// accumulator, restoring divider, rounding and output register. Uses affmi_pkg.
module affmi_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  affmi_pkg::t_cmd      i_cmd,
    input  affmi_pkg::t_in_req   i_in_req,
    input  logic                 i_out_stall,
    output affmi_pkg::t_status   o_status,
    output logic                 o_out_valid,
    output affmi_pkg::t_out_req  o_out_req
);

    localparam int AW = affmi_pkg::ACC_W;
    localparam int DW = affmi_pkg::DIV_W;

    logic [affmi_pkg::VAL_W-1:0]        r_in  [affmi_pkg::ELEMS];
    logic [affmi_pkg::VAL_W-1:0]        r_inv [affmi_pkg::ELEMS];
    logic [affmi_pkg::COF_W-1:0]        r_p   [affmi_pkg::COFS];
    logic signed [affmi_pkg::OP_W-1:0]  r_a, r_b;
    logic signed [affmi_pkg::PROD_W-1:0] r_prod;
    logic signed [AW-1:0]               r_acc;
    logic [AW-1:0]                      r_det_mag;
    logic                               r_det_neg, r_sing;
    logic [DW-1:0]                      r_rem, r_dsh;
    logic [affmi_pkg::QUO_W-1:0]        r_q;
    logic                               r_qneg, r_qsat;
    logic                               r_out_valid;
    affmi_pkg::t_out_req                r_out;

    logic [affmi_pkg::VAL_W-1:0]        rd_in, rd_inv;
    logic [affmi_pkg::COF_W-1:0]        rd_p, p_abs;
    logic signed [affmi_pkg::OP_W-1:0]  ld_val;
    logic signed [AW-1:0]               prod_ext;
    logic [AW-1:0]                      acc_abs, trn_mag;
    logic [DW-1:0]                      mn, md_sh32, md_sh33, div_diff;
    logic                               div_ge, rnd, trn_neg;
    logic [affmi_pkg::QUO_W:0]          q_rnd;
    logic [affmi_pkg::VAL_W-1:0]        div_res, trn_res;

    // saturate sign and magnitude to 32-bit two's complement
    function automatic logic [affmi_pkg::VAL_W-1:0] f_sat(input logic neg,
                                                           input logic [AW-1:0] mag);
        logic [AW-1:0] lim;
        lim = neg ? AW'(33'h1_0000_0000 >> 1) : AW'(32'h7fff_ffff);
        if (mag > lim) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        return neg ? (~mag[31:0] + 32'd1) : mag[31:0];
    endfunction

    always_comb begin
        rd_in  = r_in[i_cmd.addr];
        rd_inv = r_inv[i_cmd.addr];
        rd_p   = r_p[i_cmd.addr];
        unique case (i_cmd.src)
            affmi_pkg::SRC_IN:  ld_val = {rd_in[31], rd_in};
            affmi_pkg::SRC_INV: ld_val = {rd_inv[31], rd_inv};
            affmi_pkg::SRC_PLO: ld_val = {1'b0, rd_p[31:0]};
            default:            ld_val = {rd_p[63], rd_p[63:32]};
        endcase
        prod_ext = AW'(r_prod);
        acc_abs  = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
        p_abs    = rd_p[63] ? (~rd_p + 64'd1) : rd_p;
        mn       = DW'(p_abs) << (2 * affmi_pkg::FRAC_BITS);
        md_sh32  = DW'(r_det_mag) << 32;
        md_sh33  = DW'(r_det_mag) << 33;
        div_ge   = (r_rem >= r_dsh);
        div_diff = r_rem - r_dsh;
        rnd      = ((r_rem << 1) >= DW'(r_det_mag));
        q_rnd    = {1'b0, r_q} + (affmi_pkg::QUO_W + 1)'(rnd);
        div_res  = r_qsat ? (r_qneg ? 32'h8000_0000 : 32'h7fff_ffff)
                          : f_sat(r_qneg, AW'(q_rnd));
        // translation is minus the sum: negative exactly when the sum is positive
        trn_neg  = !r_acc[AW-1] && (r_acc != '0);
        trn_mag  = (acc_abs + (AW'(1) << (affmi_pkg::FRAC_BITS - 1)))
                   >> affmi_pkg::FRAC_BITS;
        trn_res  = f_sat(trn_neg, trn_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_in) r_in[i_in_req.element_index] <= i_in_req.element_value;
        unique case (i_cmd.ld)
            affmi_pkg::LD_A: r_a <= ld_val;
            affmi_pkg::LD_B: r_b <= ld_val;
            default: ;
        endcase
        if (i_cmd.mul) r_prod <= r_a * r_b;
        unique case (i_cmd.acc)
            affmi_pkg::ACC_CLR:   r_acc <= '0;
            affmi_pkg::ACC_LOAD:  r_acc <= prod_ext;
            affmi_pkg::ACC_ADD:   r_acc <= r_acc + prod_ext;
            affmi_pkg::ACC_SUB:   r_acc <= r_acc - prod_ext;
            affmi_pkg::ACC_ADDHI: r_acc <= r_acc + (prod_ext <<< 32);
            default: ;
        endcase
        if (i_cmd.p_wr) r_p[i_cmd.waddr] <= r_acc[affmi_pkg::COF_W-1:0];
        if (i_cmd.det_wr) begin
            r_det_mag <= acc_abs;
            r_det_neg <= r_acc[AW-1];
            r_sing    <= (r_acc == '0);
        end
        if (i_cmd.div_init) begin
            r_rem  <= mn;
            r_dsh  <= md_sh32;
            r_qsat <= (mn >= md_sh33);
            r_q    <= '0;
            r_qneg <= rd_p[63] ^ r_det_neg;
        end else if (i_cmd.div_step) begin
            if (div_ge) r_rem <= div_diff;
            r_q   <= {r_q[affmi_pkg::QUO_W-2:0], div_ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.div_fin) r_inv[i_cmd.waddr] <= div_res;
        else if (i_cmd.trn_wr) r_inv[i_cmd.waddr] <= trn_res;
        if (i_cmd.out_load) begin
            r_out.element_index_res <= i_cmd.addr;
            r_out.element_value_res <= r_sing ? '0 : rd_inv;
            r_out.singular          <= r_sing;
            r_out.last              <= (i_cmd.addr == affmi_pkg::LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.singular = r_sing;
    assign o_status.out_full = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_req         = r_out;

endmodule

>>> rtl/affine_matrix_inverse_top.sv
// Top level of the affine 3x4 matrix inverse: controller plus datapath.
// Depends on affmi_pkg, affmi_ctrl, affmi_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req) takes one Q16.16
//   element per request at its row-major index 0..11. Indexes above 11 are
//   dropped. Loads are taken one per cycle while the input is not stalled.
//   A request with index 11 stores its element and starts the inversion;
//   the input stalls until the twelfth result has been loaded out.
//   Compute walks the nine cofactors, the determinant, nine divisions in
//   the bit-serial divider (one quotient bit per cycle, the dominant term)
//   and the translation column. A singular matrix skips the divider and
//   translation.
//   Output channel (o_out_valid / i_out_stall / o_out_req) then delivers
//   twelve results in index order, one per cycle when not stalled, last
//   set on index 11. Results go through a single output register: a stall
//   holds it and pauses emission; a new input request is taken while the
//   last result still waits.
//   Reset (synchronous, active low) clears the sequencer and the output
//   valid; element stores are undefined until written.
module affine_matrix_inverse_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  affmi_pkg::t_in_req   i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output affmi_pkg::t_out_req  o_out_req
);

    affmi_pkg::t_cmd    cmd;
    affmi_pkg::t_status status;

    affmi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_idx   (i_in_req.element_index),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    affmi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

endmodule

>>> sim/affine_matrix_inverse_top_test.sv
// Self-checking test of affine_matrix_inverse_top: directed rows, then random
// 3x4 matrices, each checked against an in-bench 128-bit inverse predictor.
// Depends on affmi_pkg and the RTL of affine_matrix_inverse_top.
`timescale 1ns / 100ps

module affine_matrix_inverse_top_test;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 600;     // a bit over one full inversion
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MAXV = 32'h7fff_ffff;
    localparam logic [31:0] Q_MINV = 32'h8000_0000;
    localparam logic [3:0]  IDX_TRIG = affmi_pkg::LAST_IDX;

    // cofactor table: dst = m[a]*m[b] - m[c]*m[d]
    localparam int COF_TAB[9][5] = '{
        '{0, 5, 10, 6, 9}, '{1, 9, 2, 10, 1}, '{2, 1, 6, 2, 5},
        '{4, 6, 8, 4, 10}, '{5, 10, 0, 8, 2}, '{6, 2, 4, 0, 6},
        '{8, 4, 9, 5, 8},  '{9, 8, 1, 9, 0},  '{10, 0, 5, 1, 4}
    };

    typedef enum logic [1:0] {KN_NONE, KN_IDENT, KN_SING} t_known;
    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        t_known      known;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    affmi_pkg::t_in_req   i_in_req = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    affmi_pkg::t_out_req  o_out_req;

    logic signed [31:0]   elem_store[12];   // predictor copy of the input matrix
    affmi_pkg::t_out_req  inverse_q[$];     // expected results, oldest first
    int                   n_errors = 0;
    int                   cyc = 0;
    int                   snd_idle_pct = 0;
    int                   rcv_stall_pct = 0;
    t_dir_row             dir_tab[24];

    affine_matrix_inverse_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_req  (o_out_req)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver stall, changed on the falling edge
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < rcv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0d: %s", cyc, msg);
        n_errors++;
    endtask

    // Saturate a sign/magnitude value into 32-bit two's complement
    function automatic logic [31:0] sat_q(input logic neg, input logic [127:0] mag);
        if (neg) begin
            if (mag > 128'h8000_0000) return Q_MINV;
            return 32'(-mag);
        end
        if (mag > 128'h7fff_ffff) return Q_MAXV;
        return mag[31:0];
    endfunction

    // Inverse of the stored matrix; pushes the twelve expected results.
    // Linear part: P * 2^2F / D rounded half away from zero.
    // Translation: -(R * t) >> F, same rounding.
    task automatic predict_inverse(input t_known known);
        logic signed [127:0] ex[12];
        logic signed [127:0] cof[12];
        logic signed [127:0] det, num, acc;
        logic [127:0]        mn, md, q, r;
        logic [31:0]         res[12];
        logic                sing, neg;
        affmi_pkg::t_out_req o;
        for (int k = 0; k < 12; k++) begin
            ex[k]  = elem_store[k];
            cof[k] = '0;
            res[k] = '0;
        end
        for (int k = 0; k < 9; k++)
            cof[COF_TAB[k][0]] = ex[COF_TAB[k][1]] * ex[COF_TAB[k][2]]
                               - ex[COF_TAB[k][3]] * ex[COF_TAB[k][4]];
        det  = ex[0] * cof[0] + ex[4] * cof[1] + ex[8] * cof[2];
        sing = (det == 0);
        if (!sing) begin
            md = det[127] ? -det : det;
            for (int k = 0; k < 9; k++) begin
                num = cof[COF_TAB[k][0]] <<< (2 * affmi_pkg::FRAC_BITS);
                neg = num[127] ^ det[127];
                mn  = num[127] ? -num : num;
                q   = mn / md;
                r   = mn % md;
                if ((r << 1) >= md) q = q + 1;
                res[COF_TAB[k][0]] = sat_q(neg, q);
            end
            for (int i = 0; i < 3; i++) begin
                acc = '0;
                for (int j = 0; j < 3; j++)
                    acc = acc + $signed(res[i*4+j]) * ex[j*4+3];
                acc = -acc;
                mn  = acc[127] ? -acc : acc;
                mn  = (mn + (128'd1 << (affmi_pkg::FRAC_BITS - 1)))
                      >> affmi_pkg::FRAC_BITS;
                res[i*4+3] = sat_q(acc[127], mn);
            end
        end
        for (int k = 0; k < 12; k++) begin
            o.element_index_res = 4'(k);
            o.element_value_res = res[k];
            o.singular          = sing;
            o.last              = (k == 11);
            // rows whose answer is plain by inspection use the typed value
            if (known == KN_IDENT) begin
                o.element_value_res = (k == 0 || k == 5 || k == 10) ? Q_ONE : '0;
                o.singular          = 1'b0;
            end else if (known == KN_SING) begin
                o.element_value_res = '0;
                o.singular          = 1'b1;
            end
            inverse_q.push_back(o);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (inverse_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                affmi_pkg::t_out_req e;
                e = inverse_q.pop_front();
                if (o_out_req.element_index_res !== e.element_index_res)
                    report_mismatch($sformatf("index %0d, want %0d",
                        o_out_req.element_index_res, e.element_index_res));
                if (o_out_req.element_value_res !== e.element_value_res)
                    report_mismatch($sformatf("idx %0d value %h, want %h",
                        e.element_index_res, o_out_req.element_value_res,
                        e.element_value_res));
                if (o_out_req.singular !== e.singular)
                    report_mismatch($sformatf("idx %0d singular %b, want %b",
                        e.element_index_res, o_out_req.singular, e.singular));
                if (o_out_req.last !== e.last)
                    report_mismatch($sformatf("idx %0d last %b, want %b",
                        e.element_index_res, o_out_req.last, e.last));
            end
        end
    end

    // Drive one request; entered and left at a falling edge, valid left high
    task automatic send_elem(input logic [3:0] idx, input logic [31:0] val,
                             input t_known known);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_req.element_index = idx;
        i_in_req.element_value = val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (idx <= IDX_TRIG) begin
            elem_store[idx] = val;
            if (idx == IDX_TRIG) predict_inverse(known);
        end
        @(negedge i_clk);
    endtask

    // Mostly moderate Q16.16 values, some full range, rail and near-one values
    function automatic logic [31:0] rand_elem();
        int c;
        c = $urandom_range(9);
        if (c < 6) return 32'($urandom_range(32'h8_0000) - 32'h4_0000);
        if (c < 8) return $urandom;
        if (c == 8) begin
            case ($urandom_range(3))
                0: return Q_MAXV;
                1: return Q_MINV;
                2: return 32'h1;
                default: return 32'hffff_ffff;
            endcase
        end
        return Q_ONE + 32'($urandom_range(32'h2000) - 32'h1000);
    endfunction

    task automatic wait_idle();
        while (inverse_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] mat[12];
        int          ord[11];
        int          n_wr, tmp, j;

        dir_tab = '{
            // identity: inverse is identity, plain by inspection
            '{4'd0, Q_ONE, KN_NONE}, '{4'd1, 32'h0, KN_NONE}, '{4'd2, 32'h0, KN_NONE},
            '{4'd3, 32'h0, KN_NONE}, '{4'd4, 32'h0, KN_NONE}, '{4'd5, Q_ONE, KN_NONE},
            '{4'd6, 32'h0, KN_NONE}, '{4'd7, 32'h0, KN_NONE}, '{4'd8, 32'h0, KN_NONE},
            '{4'd9, 32'h0, KN_NONE}, '{4'd10, Q_ONE, KN_NONE},
            '{4'd11, 32'h0, KN_IDENT},
            // zero top row: singular, all-zero output
            '{4'd0, 32'h0, KN_NONE}, '{4'd1, 32'h0, KN_NONE}, '{4'd2, 32'h0, KN_NONE},
            '{4'd11, Q_MAXV, KN_SING},
            // out-of-range indexes are dropped
            '{4'd12, Q_MINV, KN_NONE}, '{4'd15, 32'hffff_ffff, KN_NONE},
            '{4'd14, 32'h0, KN_NONE},
            // rail values, checked by the predictor
            '{4'd0, Q_MINV, KN_NONE}, '{4'd1, Q_MAXV, KN_NONE}, '{4'd2, 32'h1, KN_NONE},
            '{4'd5, Q_MAXV, KN_NONE}, '{4'd11, Q_MINV, KN_NONE}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i])
            send_elem(dir_tab[i].idx, dir_tab[i].val, dir_tab[i].known);

        // random matrices, four idle/stall phases of seven matrices each
        for (int s = 0; s < 28; s++) begin
            if (s % 7 == 0) begin
                case (s / 7)
                    0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                    1: begin snd_idle_pct = 71; rcv_stall_pct = 0;  end
                    2: begin snd_idle_pct = 0;  rcv_stall_pct = 71; end
                    default: begin snd_idle_pct = 30; rcv_stall_pct = 30; end
                endcase
                // hold off until the block has drained
                i_in_valid = 1'b0;
                wait_idle();
            end
            foreach (mat[k]) mat[k] = rand_elem();
            // one in six: row 1 copies row 0 of the linear part -> singular once both are sent
            if ($urandom_range(5) == 0)
                for (int k = 0; k < 3; k++) mat[4+k] = mat[k];
            for (int k = 0; k < 11; k++) ord[k] = k;
            for (int k = 10; k > 0; k--) begin
                j = $urandom_range(k);
                tmp = ord[k]; ord[k] = ord[j]; ord[j] = tmp;
            end
            // most sets rewrite everything; some only part (older values stay)
            n_wr = ($urandom_range(5) == 0) ? $urandom_range(10) : 11;
            for (int k = 0; k < n_wr; k++) begin
                if ($urandom_range(11) == 0)
                    send_elem(4'($urandom_range(15, 12)), $urandom, KN_NONE);
                send_elem(4'(ord[k]), mat[ord[k]], KN_NONE);
            end
            send_elem(IDX_TRIG, mat[11], KN_NONE);
            if ($urandom_range(9) == 0)
                send_elem(IDX_TRIG, rand_elem(), KN_NONE);
        end
        i_in_valid = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && inverse_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
